/* src/assert_macros.svh */
// Assertion macros shared by the RTL.
// Depends on nothing; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define AST_HOLDS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define AST_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define AST_HOLDS(label, clk, rst_n, prop, msg)
`define AST_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* src/mck_pkg.sv */
// Types, register indexes, microcode program and Morse pattern table
// for the Morse character keyer. Depends on nothing.
`default_nettype none

package mck_pkg;

	localparam int DurW = 16;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_DOT         = 3'd0,
		REG_DASH        = 3'd1,
		REG_ELEMENT_GAP = 3'd2,
		REG_LETTER_GAP  = 3'd3,
		REG_WORD_GAP    = 3'd4
	} reg_idx_t;

	// microcode step addresses
	typedef enum logic [2:0] {
		STEP_IDLE   = 3'd0,
		STEP_WORD   = 3'd1,
		STEP_ON     = 3'd2,
		STEP_GAP    = 3'd3,
		STEP_LETTER = 3'd4
	} step_t;

	// duration source select
	typedef enum logic [1:0] {
		DUR_ELEM_ON  = 2'd0,
		DUR_ELEM_GAP = 2'd1,
		DUR_LETTER   = 2'd2,
		DUR_WORD     = 2'd3
	} dur_sel_t;

	// sequencing: fall through, jump, jump while elements remain, decode char
	typedef enum logic [1:0] {
		JMP_NEXT     = 2'd0,
		JMP_ALWAYS   = 2'd1,
		JMP_MORE     = 2'd2,
		JMP_DISPATCH = 2'd3
	} jmp_t;

	typedef struct packed {
		logic     emit;
		logic     key;
		dur_sel_t dur_sel;
		logic     last;
		logic     shift;
		jmp_t     jmp;
		step_t    target;
	} ctl_word_t;

	// element pattern, left aligned: bits[5] is sent first, 1 = dash
	typedef struct packed {
		logic [2:0] len;
		logic [5:0] bits;
	} pattern_t;

	// control store
	function automatic ctl_word_t ucode(input step_t pc);
		ctl_word_t w;
		w = '{emit: 1'b0, key: 1'b0, dur_sel: DUR_LETTER, last: 1'b0,
		      shift: 1'b0, jmp: JMP_DISPATCH, target: STEP_IDLE};
		case (pc)
			STEP_IDLE: begin
				w.jmp = JMP_DISPATCH;
			end
			STEP_WORD: begin
				w.emit    = 1'b1;
				w.dur_sel = DUR_WORD;
				w.jmp     = JMP_ALWAYS;
				w.target  = STEP_LETTER;
			end
			STEP_ON: begin
				w.emit    = 1'b1;
				w.key     = 1'b1;
				w.dur_sel = DUR_ELEM_ON;
				w.jmp     = JMP_NEXT;
			end
			STEP_GAP: begin
				w.emit    = 1'b1;
				w.dur_sel = DUR_ELEM_GAP;
				w.shift   = 1'b1;
				w.jmp     = JMP_MORE;
				w.target  = STEP_ON;
			end
			STEP_LETTER: begin
				w.emit    = 1'b1;
				w.dur_sel = DUR_LETTER;
				w.last    = 1'b1;
				w.jmp     = JMP_ALWAYS;
				w.target  = STEP_IDLE;
			end
			default: begin
				w.jmp    = JMP_ALWAYS;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

	function automatic pattern_t mk(input logic [2:0] len, input logic [5:0] bits);
		pattern_t p;
		p.len  = len;
		p.bits = bits;
		return p;
	endfunction

	// ITU patterns; unknown characters have length zero
	function automatic pattern_t char_pattern(input logic [7:0] c);
		pattern_t p;
		p = mk(3'd0, 6'b000000);
		case (c)
			"A": p = mk(3'd2, 6'b010000);
			"B": p = mk(3'd4, 6'b100000);
			"C": p = mk(3'd4, 6'b101000);
			"D": p = mk(3'd3, 6'b100000);
			"E": p = mk(3'd1, 6'b000000);
			"F": p = mk(3'd4, 6'b001000);
			"G": p = mk(3'd3, 6'b110000);
			"H": p = mk(3'd4, 6'b000000);
			"I": p = mk(3'd2, 6'b000000);
			"J": p = mk(3'd4, 6'b011100);
			"K": p = mk(3'd3, 6'b101000);
			"L": p = mk(3'd4, 6'b010000);
			"M": p = mk(3'd2, 6'b110000);
			"N": p = mk(3'd2, 6'b100000);
			"O": p = mk(3'd3, 6'b111000);
			"P": p = mk(3'd4, 6'b011000);
			"Q": p = mk(3'd4, 6'b110100);
			"R": p = mk(3'd3, 6'b010000);
			"S": p = mk(3'd3, 6'b000000);
			"T": p = mk(3'd1, 6'b100000);
			"U": p = mk(3'd3, 6'b001000);
			"V": p = mk(3'd4, 6'b000100);
			"W": p = mk(3'd3, 6'b011000);
			"X": p = mk(3'd4, 6'b100100);
			"Y": p = mk(3'd4, 6'b101100);
			"Z": p = mk(3'd4, 6'b110000);
			"0": p = mk(3'd5, 6'b111110);
			"1": p = mk(3'd5, 6'b011110);
			"2": p = mk(3'd5, 6'b001110);
			"3": p = mk(3'd5, 6'b000110);
			"4": p = mk(3'd5, 6'b000010);
			"5": p = mk(3'd5, 6'b000000);
			"6": p = mk(3'd5, 6'b100000);
			"7": p = mk(3'd5, 6'b110000);
			"8": p = mk(3'd5, 6'b111000);
			"9": p = mk(3'd5, 6'b111100);
			",": p = mk(3'd6, 6'b110011);
			"?": p = mk(3'd6, 6'b001100);
			"/": p = mk(3'd5, 6'b100100);
			".": p = mk(3'd6, 6'b010101);
			"-": p = mk(3'd6, 6'b100001);
			default: p = mk(3'd0, 6'b000000);
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

/* src/morse_character_keyer.sv */
// Morse character keyer: microcoded sequencer, timing registers and outputs.
// Depends on mck_pkg and assert_macros.svh.
//
// Usage:
//   Pulse start with ascii_char while busy is low; the character is taken at
//   that edge. The block then sends one key segment per cycle on
//   key_on / duration_ms / last, each marked by a one-cycle seg_valid beat.
//   A dot or dash gives an on beat and an element-gap beat; a space gives a
//   word-gap beat; every character ends with a letter-gap beat with last set.
//   Unknown characters give only the letter-gap beat.
//   The first beat passes the step register, then the output registers.
//   A character with n elements (at most six) runs an on and a gap step per
//   element, then letter and idle; a space word, letter and idle; unknown
//   characters letter and idle. The sequencer issues one control word per cycle.
//   busy is low again in the cycle that carries the last beat.
//   Timing registers are written over cfg_we / cfg_index / cfg_wdata, by the
//   user only while idle (not enforced); indexes beyond the list are ignored.
//   Reset (arst_n low) loads the default timings and returns to idle.
//   The receiver cannot stall: each beat is valid for one cycle only.
`default_nettype none
`include "assert_macros.svh"

module morse_character_keyer import mck_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [7:0]       ascii_char,
	input  wire logic             cfg_we,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [DurW-1:0]  cfg_wdata,
	output logic                  seg_valid,
	output logic                  key_on,
	output logic [DurW-1:0]       duration_ms,
	output logic                  last
);

	step_t           pc_q;
	logic [2:0]      pat_len_q;
	logic [5:0]      pat_bits_q;
	logic [DurW-1:0] dot_q, dash_q, elem_gap_q, letter_gap_q, word_gap_q;
	logic            valid_q, key_q, last_q;
	logic [DurW-1:0] dur_q;

	ctl_word_t       ctl;
	pattern_t        new_pat;
	logic            accept;
	logic            more;
	step_t           pc_next;
	logic [DurW-1:0] dur_mux;

	assign ctl     = ucode(pc_q);
	assign new_pat = char_pattern(ascii_char);
	assign busy    = (pc_q != STEP_IDLE);
	assign accept  = start && !busy;
	assign more    = (pat_len_q != 3'd1);

	// next step
	always_comb begin
		pc_next = pc_q;
		case (ctl.jmp)
			JMP_NEXT:   pc_next = step_t'(pc_q + 3'd1);
			JMP_ALWAYS: pc_next = ctl.target;
			JMP_MORE:   pc_next = more ? ctl.target : step_t'(pc_q + 3'd1);
			JMP_DISPATCH: begin
				if (!accept) begin
					pc_next = STEP_IDLE;
				end else if (new_pat.len != 3'd0) begin
					pc_next = STEP_ON;
				end else if (ascii_char == " ") begin
					pc_next = STEP_WORD;
				end else begin
					pc_next = STEP_LETTER;
				end
			end
			default: pc_next = STEP_IDLE;
		endcase
	end

	// duration select
	always_comb begin
		case (ctl.dur_sel)
			DUR_ELEM_ON:  dur_mux = pat_bits_q[5] ? dash_q : dot_q;
			DUR_ELEM_GAP: dur_mux = elem_gap_q;
			DUR_LETTER:   dur_mux = letter_gap_q;
			DUR_WORD:     dur_mux = word_gap_q;
			default:      dur_mux = letter_gap_q;
		endcase
	end

	// step counter and output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= STEP_IDLE;
			valid_q <= 1'b0;
		end else begin
			pc_q    <= pc_next;
			valid_q <= ctl.emit;
		end
	end

	// pattern shifter
	always_ff @(posedge clk) begin
		if (accept) begin
			pat_len_q  <= new_pat.len;
			pat_bits_q <= new_pat.bits;
		end else if (ctl.shift) begin
			pat_len_q  <= pat_len_q - 3'd1;
			pat_bits_q <= {pat_bits_q[4:0], 1'b0};
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		key_q  <= ctl.key;
		last_q <= ctl.last;
		dur_q  <= dur_mux;
	end

	// timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q        <= DurW'(100);
			dash_q       <= DurW'(300);
			elem_gap_q   <= DurW'(100);
			letter_gap_q <= DurW'(300);
			word_gap_q   <= DurW'(700);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DOT:         dot_q        <= cfg_wdata;
				REG_DASH:        dash_q       <= cfg_wdata;
				REG_ELEMENT_GAP: elem_gap_q   <= cfg_wdata;
				REG_LETTER_GAP:  letter_gap_q <= cfg_wdata;
				REG_WORD_GAP:    word_gap_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign seg_valid   = valid_q;
	assign key_on      = key_q;
	assign duration_ms = dur_q;
	assign last        = last_q;

	// checks
	`AST_HOLDS(a_last_idle, clk, arst_n, (seg_valid && last) |-> !busy, "last beat while busy")
	`AST_HOLDS(a_accept, clk, arst_n, accept |=> (busy && !seg_valid), "accept did not start")
	`AST_NEVER(a_on_last, clk, arst_n, seg_valid && key_on && last, "key-on beat marked last")
	`AST_HOLDS(a_on_gap, clk, arst_n, (seg_valid && key_on) |=> (seg_valid && !key_on),
		"key-on beat not followed by gap")

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the Morse character keyer.
// Depends on mck_pkg and the morse_character_keyer RTL; predicts key segments
// from its own ITU table and compares every seg_valid beat in order.
`timescale 1ns / 1ps

module testbench;
	import mck_pkg::*;

	localparam int NUM_TIMING = int'(REG_WORD_GAP) + 1;
	localparam int SETTLE     = 6;
	localparam int LIMIT      = 200000;
	localparam int BATCH      = 25;

	// one expected key segment
	typedef struct packed {
		logic            key;
		logic [DurW-1:0] dur;
		logic            last_seg;
	} key_segment_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	logic [7:0]      ascii_char = '0;
	logic            cfg_we = 1'b0;
	logic [2:0]      cfg_index = REG_DOT;
	logic [DurW-1:0] cfg_wdata = '0;
	logic            busy;
	logic            seg_valid;
	logic            key_on;
	logic [DurW-1:0] duration_ms;
	logic            last;

	logic [7:0]      chars_pending [$];
	key_segment_t    segs_due [$];
	key_segment_t    seg_want;
	logic [DurW-1:0] timing [NUM_TIMING];
	int              sender_idle_pct = 7;
	int              errors = 0;
	int              chars_sent = 0;
	int              segs_checked = 0;
	int              settings_used = 1;
	int              cycles = 0;

	morse_character_keyer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.ascii_char  (ascii_char),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.seg_valid   (seg_valid),
		.key_on      (key_on),
		.duration_ms (duration_ms),
		.last        (last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("%0t: timeout with %0d segments still due", $time, segs_due.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// ITU pattern for a character; empty for space and anything unknown
	function automatic string itu_code(input logic [7:0] c);
		case (c)
			"A": return ".-";    "B": return "-...";  "C": return "-.-.";  "D": return "-..";
			"E": return ".";     "F": return "..-.";  "G": return "--.";   "H": return "....";
			"I": return "..";    "J": return ".---";  "K": return "-.-";   "L": return ".-..";
			"M": return "--";    "N": return "-.";    "O": return "---";   "P": return ".--.";
			"Q": return "--.-";  "R": return ".-.";   "S": return "...";   "T": return "-";
			"U": return "..-";   "V": return "...-";  "W": return ".--";   "X": return "-..-";
			"Y": return "-.--";  "Z": return "--..";
			"0": return "-----"; "1": return ".----"; "2": return "..---"; "3": return "...--";
			"4": return "....-"; "5": return "....."; "6": return "-...."; "7": return "--...";
			"8": return "---.."; "9": return "----.";
			",": return "--..--"; "?": return "..--.."; "/": return "-..-.";
			".": return ".-.-.-"; "-": return "-....-";
			default: return "";
		endcase
	endfunction

	// expected segments for one character under the current timings
	task automatic queue_key_segments(input logic [7:0] c);
		string code;
		int    i;
		code = itu_code(c);
		for (i = 0; i < code.len(); i++) begin
			if (code.getc(i) == "-")
				segs_due.push_back('{1'b1, timing[REG_DASH], 1'b0});
			else
				segs_due.push_back('{1'b1, timing[REG_DOT], 1'b0});
			segs_due.push_back('{1'b0, timing[REG_ELEMENT_GAP], 1'b0});
		end
		if (c == " ")
			segs_due.push_back('{1'b0, timing[REG_WORD_GAP], 1'b0});
		segs_due.push_back('{1'b0, timing[REG_LETTER_GAP], 1'b1});
	endtask

	// character driver: holds start while busy, idles at random
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && busy)) begin
			if (chars_pending.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				start      <= 1'b1;
				ascii_char <= chars_pending.pop_front();
			end else begin
				start      <= 1'b0;
				ascii_char <= 8'($urandom);
			end
		end
	end

	// segment monitor: checks each beat, then records newly accepted characters
	always @(posedge clk) begin
		if (arst_n) begin
			if (seg_valid) begin
				if (segs_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected segment key_on=%0b duration_ms=%0d last=%0b",
						$time, key_on, duration_ms, last);
				end else begin
					seg_want = segs_due.pop_front();
					segs_checked++;
					if (key_on !== seg_want.key) begin
						errors++;
						$display("%0t: key_on expected %0b got %0b",
							$time, seg_want.key, key_on);
					end
					if (duration_ms !== seg_want.dur) begin
						errors++;
						$display("%0t: duration_ms expected %0d got %0d",
							$time, seg_want.dur, duration_ms);
					end
					if (last !== seg_want.last_seg) begin
						errors++;
						$display("%0t: last expected %0b got %0b",
							$time, seg_want.last_seg, last);
					end
				end
			end
			if (start && !busy) begin
				queue_key_segments(ascii_char);
				chars_sent++;
			end
		end
	end

	// one register write beat; cfg_we stays high across back-to-back writes
	task automatic write_timing(input logic [2:0] idx, input logic [DurW-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx < NUM_TIMING)
			timing[idx] = val;
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we    <= 1'b0;
		cfg_wdata <= DurW'($urandom);
		settings_used++;
	endtask

	// block idle: nothing queued, nothing presented, nothing due
	task automatic wait_idle();
		do @(negedge clk);
		while (chars_pending.size() != 0 || start || segs_due.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic [DurW-1:0] pick_timing();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return DurW'($urandom_range(1, 8));
			default: return DurW'($urandom);
		endcase
	endfunction

	task automatic random_timings();
		int i;
		for (i = 0; i < NUM_TIMING; i++)
			write_timing(3'(i), pick_timing());
		// an index past the list must leave the timings alone
		if ($urandom_range(0, 2) == 0)
			write_timing(3'($urandom_range(NUM_TIMING, 7)), DurW'($urandom));
		end_writes();
	endtask

	function automatic logic [7:0] pick_char();
		string known;
		int    r;
		known = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789,?/.-";
		r = $urandom_range(0, 99);
		if (r < 65)
			return known.getc($urandom_range(0, known.len() - 1));
		else if (r < 77)
			return " ";
		else
			return 8'($urandom);
	endfunction

	initial begin
		int p;
		int b;
		int n;
		int idx;
		timing[REG_DOT]         = 16'd100;
		timing[REG_DASH]        = 16'd300;
		timing[REG_ELEMENT_GAP] = 16'd100;
		timing[REG_LETTER_GAP]  = 16'd300;
		timing[REG_WORD_GAP]    = 16'd700;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: reset timings, longest and shortest patterns, space, unknowns
		chars_pending = '{"E", "T", "A", "Z", "0", "9", ",", "?", ".", "-", "/", " ",
			8'h00, 8'hFF, "a", "@", "[", 8'h80, "5", "Q"};
		wait_idle();

		// short marks, longest dash, zero gaps, longest word gap; unused indexes
		write_timing(REG_DOT, 16'd1);
		write_timing(REG_DASH, 16'hFFFF);
		write_timing(REG_ELEMENT_GAP, 16'd0);
		write_timing(REG_LETTER_GAP, 16'd0);
		write_timing(REG_WORD_GAP, 16'hFFFF);
		for (idx = NUM_TIMING; idx < 8; idx++)
			write_timing(3'(idx), (idx % 2) ? 16'hFFFF : 16'h0000);
		end_writes();
		chars_pending = '{",", " ", "T", 8'h7F, "E"};
		wait_idle();

		// zero-length marks, longest gaps, zero word gap
		write_timing(REG_DOT, 16'd0);
		write_timing(REG_DASH, 16'd0);
		write_timing(REG_ELEMENT_GAP, 16'hFFFF);
		write_timing(REG_LETTER_GAP, 16'hFFFF);
		write_timing(REG_WORD_GAP, 16'd0);
		end_writes();
		chars_pending = '{"-", " ", "H"};
		wait_idle();

		// random: sender idles 7%, then 65%, then never; new timings per batch
		for (p = 0; p < 3; p++) begin
			sender_idle_pct = (p == 0) ? 7 : (p == 1) ? 65 : 0;
			for (b = 0; b < 4; b++) begin
				random_timings();
				for (n = 0; n < BATCH; n++)
					chars_pending.push_back(pick_char());
				wait_idle();
			end
		end

		repeat (SETTLE) @(posedge clk);
		if (segs_due.size() != 0) begin
			errors++;
			$display("%0t: %0d segments never arrived", $time, segs_due.size());
		end
		$display("Keyed %0d characters under %0d timing settings, %0d segments checked.",
			chars_sent, settings_used, segs_checked);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* morse_character_keyer.f */
+incdir+src
src/mck_pkg.sv
src/morse_character_keyer.sv
sim/testbench.sv
